// ===== rtl/patch_column_scaler_top_macros.svh =====
// assertion macros for the patch column scaler top level
// expects aclk and aresetn in the scope of every use
`ifndef PATCH_COLUMN_SCALER_TOP_MACROS_SVH
`define PATCH_COLUMN_SCALER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcs_pkg.sv =====
// shared types, widths and constants of the patch column scaler
// no dependencies; used by every rtl module through pcs_pkg:: names
`timescale 1ns / 1ps

package pcs_pkg;

    // virtual screen and fixed point format
    localparam int VIRTUAL_WIDTH  = 320;
    localparam int VIRTUAL_HEIGHT = 200;
    localparam int FRAC_BITS      = 16;

    // configuration register widths and codes
    localparam int SW_W       = 12;
    localparam int SH_W       = 11;
    localparam int PITCH_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 2'd2;

    localparam int SW_RESET_I    = 320;
    localparam int SH_RESET_I    = 200;
    localparam int PITCH_RESET_I = 320;
    localparam logic [SW_W-1:0]    SW_RESET    = SW_W'(SW_RESET_I);
    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(PITCH_RESET_I);

    // height clamp
    localparam logic [SH_W-1:0] H_MIN = SH_W'(1);
    localparam logic [SH_W-1:0] H_MAX = SH_W'(1600);

    // row step (24 bits, 8.16) and inverse step (20 bits, 4.16)
    localparam int STEP_W    = 24;
    localparam int INVSTEP_W = 20;
    localparam logic [STEP_W-1:0] STEP_RESET =
        STEP_W'((VIRTUAL_HEIGHT * (1 << FRAC_BITS)) / SH_RESET_I);
    localparam logic [INVSTEP_W-1:0] INVSTEP_RESET =
        INVSTEP_W'((SH_RESET_I * (1 << FRAC_BITS)) / VIRTUAL_HEIGHT);

    // serial divider for the row step: dividend 200 << 16
    localparam int DIVD_W  = SH_W + FRAC_BITS;
    localparam int DCNT_W  = $clog2(DIVD_W);
    localparam logic [DIVD_W-1:0] STEP_NUMER =
        DIVD_W'(VIRTUAL_HEIGHT * (1 << FRAC_BITS));

    // inverse step by reciprocal: ceil(2^32 / 200), exact up to height 1600
    localparam int INV_RECIP_W      = 25;
    localparam int INV_RECIP_PROD_W = SH_W + INV_RECIP_W;
    localparam logic [INV_RECIP_W-1:0] INV_RECIP =
        INV_RECIP_W'(((64'd1 << (2 * FRAC_BITS)) + 64'(VIRTUAL_HEIGHT) - 64'd1)
                     / 64'(VIRTUAL_HEIGHT));

    // column mapping: /320 done as >>6 then *reciprocal of 5
    localparam int COL_SHIFT   = 6;
    localparam int COL_ODD     = VIRTUAL_WIDTH / (1 << COL_SHIFT);
    localparam int RECIP_SHIFT = 18;
    localparam int COL_RECIP   = ((1 << RECIP_SHIFT) + COL_ODD - 1) / COL_ODD;
    localparam int PROD_W      = 22;
    localparam int RPROD_W     = 32;
    localparam int Q_W         = 13;

    // item fields
    localparam int X_W    = 9;
    localparam int BYTE_W = 8;
    localparam int COL_W  = 11;
    localparam int REP_W  = 3;
    localparam logic [REP_W-1:0] REP_MAX = '1;
    localparam logic [BYTE_W-1:0] END_MARK = 8'hff;

    // row generation
    localparam int ROW_W       = 12;
    localparam int ACC_W       = 32;
    localparam int ACC_HI_W    = ACC_W - FRAC_BITS;
    localparam int OFFS_W      = 24;
    localparam int INV_PROD_W  = BYTE_W + INVSTEP_W;
    localparam int OFFS_PROD_W = ROW_W + 1 + PITCH_W;
    localparam int MAX_ROWS    = 8;
    localparam int NCNT_W      = $clog2(MAX_ROWS + 1);

    // stream packing
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [5:0] {
        PH_TOP  = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_PAD1 = 6'b000100,
        PH_PIX  = 6'b001000,
        PH_PAD2 = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    typedef enum logic {
        CMD_POST  = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_kind_t;

    // one unit of work for the back end
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;    // length byte or pixel value
        logic [BYTE_W-1:0] aux;     // post top row or pixel index
        logic [COL_W-1:0]  column;
        logic [REP_W-1:0]  rep;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic                 busy;
        logic [STEP_W-1:0]    step;
        logic [INVSTEP_W-1:0] invstep;
    } row_steps_t;

endpackage

// ===== rtl/patch_column_scaler_top.sv =====
// top level of the patch column scaler: config registers, front end,
// command queue, row back end and step divider; uses pcs_pkg and the macro header
`timescale 1ns / 1ps
`include "patch_column_scaler_top_macros.svh"

// channel   dir  handshake           payload
// s_        in   s_tvalid/s_tready   tuser: column_start; tdata: column_x, data_byte
// m_        out  m_tvalid/m_tready   tdata: pixel_offset, pixel_value, span_width;
//                                    tlast: last_of_run
// cfg_      in   cfg_we              cfg_addr selects register, cfg_wdata value
//
// the front end finishes one byte before it takes the next; a byte that starts a column
// goes through a column multiply and two reciprocal multiplies, then classification
// the back end fetches a command, then reads a post header or checks a pixel, then
// multiplies and sends a span for each row it covers; one pixel byte gives at most 8 spans
// a 4-entry command queue lets the front run ahead while spans drain
// writing screen_height runs one 27-step division; input is held off while it runs
// reset is synchronous, active low; there is no memory clearing pass

module patch_column_scaler_top #(
    parameter int QUEUE_DEPTH = pcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pcs_pkg::S_TDATA_W-1:0]  s_tdata,   // [8:0] column_x, [16:9] data_byte
    input  logic [0:0]                     s_tuser,   // [0] column_start
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcs_pkg::M_TDATA_W-1:0]  m_tdata,   // [23:0] pixel_offset,
                                                      // [31:24] pixel_value, [34:32] span_width
    output logic                           m_tlast,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic [pcs_pkg::SW_W-1:0]    screen_width_reg, screen_width_next;
    logic [pcs_pkg::PITCH_W-1:0] line_pitch_reg, line_pitch_next;
    logic                        height_load;

    pcs_pkg::row_steps_t  steps;
    pcs_pkg::queue_stat_t qstat;
    pcs_pkg::cmd_t        push_cmd;
    pcs_pkg::cmd_t        pop_cmd;
    logic                 push;
    logic                 pop;

    logic [pcs_pkg::OFFS_W-1:0] out_offset;
    logic [pcs_pkg::BYTE_W-1:0] out_value;
    logic [pcs_pkg::REP_W-1:0]  out_span;

    // register writes; height goes straight to the step divider
    always_comb begin
        screen_width_next = screen_width_reg;
        line_pitch_next   = line_pitch_reg;
        height_load       = 1'b0;
        if (cfg_we) begin
            case (cfg_addr)
                pcs_pkg::REG_SCREEN_WIDTH:  screen_width_next = cfg_wdata[pcs_pkg::SW_W-1:0];
                pcs_pkg::REG_SCREEN_HEIGHT: height_load       = 1'b1;
                pcs_pkg::REG_LINE_PITCH:    line_pitch_next   = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg <= pcs_pkg::SW_RESET;
            line_pitch_reg   <= pcs_pkg::PITCH_RESET;
        end else begin
            screen_width_reg <= screen_width_next;
            line_pitch_reg   <= line_pitch_next;
        end
    end

    // 8.16 row step and 4.16 inverse step
    pcs_step_div u_step_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (height_load),
        .height  (cfg_wdata[pcs_pkg::SH_W-1:0]),
        .steps   (steps)
    );

    // parse and classify the post stream
    pcs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_start     (s_tuser[0]),
        .in_x         (s_tdata[pcs_pkg::X_W-1:0]),
        .in_byte      (s_tdata[pcs_pkg::X_W +: pcs_pkg::BYTE_W]),
        .screen_width (screen_width_reg),
        .hold         (steps.busy),
        .qstat        (qstat),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // decouples parsing from span generation
    pcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .qstat    (qstat)
    );

    // rows, offsets and the output register
    pcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .qstat      (qstat),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .steps      (steps),
        .line_pitch (line_pitch_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_offset   (out_offset),
        .m_value    (out_value),
        .m_span     (out_span),
        .m_last     (m_tlast)
    );

    // pack result fields, zero fill to whole bytes
    assign m_tdata = {
        (pcs_pkg::M_TDATA_W - pcs_pkg::OFFS_W - pcs_pkg::BYTE_W - pcs_pkg::REP_W)'(0),
        out_span, out_value, out_offset
    };

    // checks
    `PCS_ASSERT_SAME(a_div_holds_input, steps.busy, !s_tready, "input accepted while steps derive")
    `PCS_ASSERT_SAME(a_push_has_room, push, !qstat.full, "command pushed into a full queue")
    `PCS_ASSERT_SAME(a_span_nonzero, m_tvalid, out_span != '0, "span of zero width emitted")
    `PCS_ASSERT_NEXT(a_height_starts_div, cfg_we && cfg_addr == pcs_pkg::REG_SCREEN_HEIGHT, steps.busy, "height write did not start the divider")

endmodule

// ===== rtl/pcs_step_div.sv =====
// derives the 8.16 row step and 4.16 inverse step from a written height
// restoring divider for the step, reciprocal multiply for the inverse; uses pcs_pkg
`timescale 1ns / 1ps

module pcs_step_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic [pcs_pkg::SH_W-1:0] height,
    output pcs_pkg::row_steps_t     steps
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_STEP = 2'b10
    } div_state_t;

    div_state_t state_reg, state_next;
    logic [pcs_pkg::DIVD_W-1:0]    work_reg, work_next;
    logic [pcs_pkg::SH_W-1:0]      rem_reg, rem_next;
    logic [pcs_pkg::SH_W-1:0]      divisor_reg, divisor_next;
    logic [pcs_pkg::DCNT_W-1:0]    count_reg, count_next;
    logic [pcs_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [pcs_pkg::INVSTEP_W-1:0] invstep_reg, invstep_next;

    logic [pcs_pkg::SH_W-1:0]   h_eff;
    logic [pcs_pkg::INV_RECIP_PROD_W-1:0] inv_prod;
    logic [pcs_pkg::SH_W:0]     rem_shift;
    logic [pcs_pkg::SH_W:0]     rem_diff;
    logic                       rem_ge;
    logic [pcs_pkg::SH_W-1:0]   rem_step;
    logic [pcs_pkg::DIVD_W-1:0] work_step;

    always_comb begin
        if (height == '0) begin
            h_eff = pcs_pkg::H_MIN;
        end else if (height > pcs_pkg::H_MAX) begin
            h_eff = pcs_pkg::H_MAX;
        end else begin
            h_eff = height;
        end
    end

    // h * 2^16 / 200 through the rounded-up reciprocal, then drop 16 bits
    assign inv_prod = pcs_pkg::INV_RECIP_PROD_W'(h_eff)
                    * pcs_pkg::INV_RECIP_PROD_W'(pcs_pkg::INV_RECIP);

    // one restoring step
    always_comb begin
        rem_shift = {rem_reg, work_reg[pcs_pkg::DIVD_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
        rem_step  = rem_ge ? rem_diff[pcs_pkg::SH_W-1:0] : rem_shift[pcs_pkg::SH_W-1:0];
        work_step = {work_reg[pcs_pkg::DIVD_W-2:0], rem_ge};
    end

    always_comb begin
        state_next   = state_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        invstep_next = invstep_reg;

        case (state_reg)
            D_IDLE: begin
            end
            D_STEP: begin
                work_next  = work_step;
                rem_next   = rem_step;
                count_next = count_reg - 1'b1;
                if (count_reg == '0) begin
                    step_next  = work_step[pcs_pkg::STEP_W-1:0];
                    state_next = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase

        // a new height restarts the whole derivation
        if (load) begin
            work_next    = pcs_pkg::STEP_NUMER;
            rem_next     = '0;
            divisor_next = h_eff;
            count_next   = pcs_pkg::DCNT_W'(pcs_pkg::DIVD_W - 1);
            invstep_next = inv_prod[pcs_pkg::FRAC_BITS +: pcs_pkg::INVSTEP_W];
            state_next   = D_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= D_IDLE;
            step_reg    <= pcs_pkg::STEP_RESET;
            invstep_reg <= pcs_pkg::INVSTEP_RESET;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            invstep_reg <= invstep_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        count_reg   <= count_next;
    end

    assign steps.busy    = (state_reg != D_IDLE);
    assign steps.step    = step_reg;
    assign steps.invstep = invstep_reg;

endmodule

// ===== rtl/pcs_queue.sv =====
// command queue between the parsing front end and the row back end
// memory with registered read data; uses pcs_pkg::cmd_t
`timescale 1ns / 1ps

module pcs_queue #(
    parameter int DEPTH = pcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  pcs_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output pcs_pkg::cmd_t        pop_cmd,
    output pcs_pkg::queue_stat_t qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcs_pkg::cmd_t mem [DEPTH];
    pcs_pkg::cmd_t rd_data_reg;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok, pop_ok;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign push_ok     = push && !qstat.full;
    assign pop_ok      = pop && !qstat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ok) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign pop_cmd = rd_data_reg;

endmodule

// ===== rtl/pcs_front.sv =====
// front end: accepts stream bytes, maps the column, walks the post format
// pushes post and pixel commands into pcs_queue; uses pcs_pkg
`timescale 1ns / 1ps

module pcs_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_start,
    input  logic [pcs_pkg::X_W-1:0]    in_x,
    input  logic [pcs_pkg::BYTE_W-1:0] in_byte,
    input  logic [pcs_pkg::SW_W-1:0]   screen_width,
    input  logic                       hold,
    input  pcs_pkg::queue_stat_t       qstat,
    output logic                       push,
    output pcs_pkg::cmd_t              push_cmd
);

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_MUL   = 5'b00010,
        F_Q0    = 5'b00100,
        F_Q1    = 5'b01000,
        F_CLASS = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;
    pcs_pkg::phase_t phase_reg, phase_next;

    logic                       start_reg, start_next;
    logic [pcs_pkg::X_W-1:0]    x_reg, x_next;
    logic [pcs_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic [pcs_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [pcs_pkg::Q_W-1:0]    q0_reg, q0_next;
    logic [pcs_pkg::Q_W-1:0]    q1_reg, q1_next;
    logic [pcs_pkg::BYTE_W-1:0] post_top_reg, post_top_next;
    logic [pcs_pkg::BYTE_W-1:0] post_len_reg, post_len_next;
    logic [pcs_pkg::BYTE_W-1:0] pix_idx_reg, pix_idx_next;
    logic [pcs_pkg::COL_W-1:0]  col_reg, col_next;
    logic [pcs_pkg::REP_W-1:0]  rep_reg, rep_next;

    logic [pcs_pkg::RPROD_W-1:0] recip_prod;
    logic [pcs_pkg::Q_W-1:0]     recip_q;
    logic [pcs_pkg::Q_W-1:0]     rep_diff;
    logic [pcs_pkg::BYTE_W-1:0]  pix_inc;

    // classification of the held byte
    pcs_pkg::phase_t             phase_eff;
    pcs_pkg::phase_t             cls_phase;
    logic                        cls_push;
    pcs_pkg::cmd_t               cls_cmd;
    logic [pcs_pkg::BYTE_W-1:0]  cls_top;
    logic [pcs_pkg::BYTE_W-1:0]  cls_len;
    logic [pcs_pkg::BYTE_W-1:0]  cls_pix;
    logic                        advance;

    assign in_ready = (state_reg == F_IDLE) && !hold;

    assign recip_prod = pcs_pkg::RPROD_W'(prod_reg[pcs_pkg::PROD_W-1:pcs_pkg::COL_SHIFT])
                      * pcs_pkg::RPROD_W'(pcs_pkg::COL_RECIP);
    assign recip_q    = recip_prod[pcs_pkg::RECIP_SHIFT +: pcs_pkg::Q_W];
    assign rep_diff   = q1_reg - q0_reg;
    assign pix_inc    = pix_idx_reg + 1'b1;
    assign phase_eff  = start_reg ? pcs_pkg::PH_TOP : phase_reg;

    always_comb begin
        cls_phase = phase_eff;
        cls_push  = 1'b0;
        cls_top   = post_top_reg;
        cls_len   = post_len_reg;
        cls_pix   = pix_idx_reg;
        cls_cmd   = '0;

        case (phase_eff)
            pcs_pkg::PH_TOP: begin
                if (byte_reg == pcs_pkg::END_MARK) begin
                    cls_phase = pcs_pkg::PH_DONE;
                end else begin
                    cls_top   = byte_reg;
                    cls_phase = pcs_pkg::PH_LEN;
                end
            end
            pcs_pkg::PH_LEN: begin
                cls_push       = 1'b1;
                cls_cmd.kind   = pcs_pkg::CMD_POST;
                cls_cmd.data   = byte_reg;
                cls_cmd.aux    = post_top_reg;
                cls_cmd.column = col_reg;
                cls_cmd.rep    = rep_reg;
                cls_len        = byte_reg;
                cls_pix        = '0;
                cls_phase      = pcs_pkg::PH_PAD1;
            end
            pcs_pkg::PH_PAD1: begin
                cls_phase = (post_len_reg != '0) ? pcs_pkg::PH_PIX : pcs_pkg::PH_PAD2;
            end
            pcs_pkg::PH_PIX: begin
                cls_push       = 1'b1;
                cls_cmd.kind   = pcs_pkg::CMD_PIXEL;
                cls_cmd.data   = byte_reg;
                cls_cmd.aux    = pix_idx_reg;
                cls_cmd.column = col_reg;
                cls_cmd.rep    = rep_reg;
                cls_pix        = pix_inc;
                cls_phase      = (pix_inc == post_len_reg) ? pcs_pkg::PH_PAD2
                                                           : pcs_pkg::PH_PIX;
            end
            pcs_pkg::PH_PAD2: begin
                cls_phase = pcs_pkg::PH_TOP;
            end
            pcs_pkg::PH_DONE: begin
                cls_phase = pcs_pkg::PH_DONE;
            end
            default: begin
                cls_phase = pcs_pkg::PH_TOP;
            end
        endcase
    end

    assign advance = !cls_push || !qstat.full;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        start_next    = start_reg;
        x_next        = x_reg;
        byte_next     = byte_reg;
        prod_next     = prod_reg;
        q0_next       = q0_reg;
        q1_next       = q1_reg;
        post_top_next = post_top_reg;
        post_len_next = post_len_reg;
        pix_idx_next  = pix_idx_reg;
        col_next      = col_reg;
        rep_next      = rep_reg;
        push          = 1'b0;
        push_cmd      = cls_cmd;

        case (state_reg)
            F_IDLE: begin
                if (in_valid && in_ready) begin
                    start_next = in_start;
                    x_next     = in_x;
                    byte_next  = in_byte;
                    state_next = in_start ? F_MUL : F_CLASS;
                end
            end
            F_MUL: begin
                prod_next  = pcs_pkg::PROD_W'(screen_width) * pcs_pkg::PROD_W'(x_reg);
                state_next = F_Q0;
            end
            F_Q0: begin
                q0_next    = recip_q;
                prod_next  = prod_reg + pcs_pkg::PROD_W'(screen_width);
                state_next = F_Q1;
            end
            F_Q1: begin
                q1_next    = recip_q;
                state_next = F_CLASS;
            end
            F_CLASS: begin
                if (advance) begin
                    push          = cls_push;
                    phase_next    = cls_phase;
                    post_top_next = cls_top;
                    post_len_next = cls_len;
                    pix_idx_next  = cls_pix;
                    if (start_reg) begin
                        col_next = q0_reg[pcs_pkg::COL_W-1:0];
                        rep_next = (rep_diff > pcs_pkg::Q_W'(pcs_pkg::REP_MAX))
                                 ? pcs_pkg::REP_MAX : rep_diff[pcs_pkg::REP_W-1:0];
                    end
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            phase_reg    <= pcs_pkg::PH_TOP;
            post_top_reg <= '0;
            post_len_reg <= '0;
            pix_idx_reg  <= '0;
            col_reg      <= '0;
            rep_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            post_top_reg <= post_top_next;
            post_len_reg <= post_len_next;
            pix_idx_reg  <= pix_idx_next;
            col_reg      <= col_next;
            rep_reg      <= rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        x_reg     <= x_next;
        byte_reg  <= byte_next;
        prod_reg  <= prod_next;
        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
    end

endmodule

// ===== rtl/pcs_back.sv =====
// back end: turns post and pixel commands into scaled row spans
// one multiplier per stage, output register toward the stream; uses pcs_pkg
`timescale 1ns / 1ps

module pcs_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pcs_pkg::queue_stat_t        qstat,
    output logic                        pop,
    input  pcs_pkg::cmd_t               pop_cmd,
    input  pcs_pkg::row_steps_t         steps,
    input  logic [pcs_pkg::PITCH_W-1:0] line_pitch,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pcs_pkg::OFFS_W-1:0]  m_offset,
    output logic [pcs_pkg::BYTE_W-1:0]  m_value,
    output logic [pcs_pkg::REP_W-1:0]   m_span,
    output logic                        m_last
);

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_FETCH = 7'b0000010,
        B_TOP   = 7'b0000100,
        B_TOT   = 7'b0001000,
        B_CHK   = 7'b0010000,
        B_MUL   = 7'b0100000,
        B_OUT   = 7'b1000000
    } back_state_t;

    back_state_t state_reg, state_next;
    pcs_pkg::cmd_t cmd_reg, cmd_next;

    logic [pcs_pkg::BYTE_W-1:0] top_byte_reg, top_byte_next;
    logic [pcs_pkg::ROW_W-1:0]  top_reg, top_next;
    logic [pcs_pkg::ROW_W-1:0]  total_reg, total_next;
    logic [pcs_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [pcs_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [pcs_pkg::NCNT_W-1:0] n_reg, n_next;
    logic [pcs_pkg::COL_W-1:0]  col_reg, col_next;
    logic [pcs_pkg::REP_W-1:0]  rep_reg, rep_next;
    logic [pcs_pkg::OFFS_W-1:0] prod_reg, prod_next;

    logic                       m_valid_reg, m_valid_next;
    logic [pcs_pkg::OFFS_W-1:0] m_offset_reg, m_offset_next;
    logic [pcs_pkg::BYTE_W-1:0] m_value_reg, m_value_next;
    logic [pcs_pkg::REP_W-1:0]  m_span_reg, m_span_next;
    logic                       m_last_reg, m_last_next;

    logic [pcs_pkg::BYTE_W-1:0]      mul_a;
    logic [pcs_pkg::INV_PROD_W-1:0]  inv_prod;
    logic [pcs_pkg::ROW_W-1:0]       inv_rows;
    logic [pcs_pkg::ROW_W:0]         row_sum;
    logic [pcs_pkg::OFFS_PROD_W-1:0] offs_prod;
    logic                            more_rows;
    logic                            out_free;

    // shared scale by the inverse step: row count of a post, top row for each pixel
    assign mul_a    = (state_reg == B_CHK) ? top_byte_reg : cmd_reg.data;
    assign inv_prod = pcs_pkg::INV_PROD_W'(mul_a) * pcs_pkg::INV_PROD_W'(steps.invstep);
    assign inv_rows = inv_prod[pcs_pkg::FRAC_BITS +: pcs_pkg::ROW_W];

    assign row_sum   = {1'b0, top_reg} + {1'b0, row_reg};
    assign offs_prod = pcs_pkg::OFFS_PROD_W'(row_sum) * pcs_pkg::OFFS_PROD_W'(line_pitch);

    // next row still lands on this source pixel, inside the post and under the per-pixel span limit
    assign more_rows = (row_reg < total_reg)
                    && (n_reg < pcs_pkg::NCNT_W'(pcs_pkg::MAX_ROWS))
                    && (acc_reg[pcs_pkg::ACC_W-1:pcs_pkg::FRAC_BITS]
                        == pcs_pkg::ACC_HI_W'(cmd_reg.aux));

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        top_byte_next = top_byte_reg;
        top_next      = top_reg;
        total_next    = total_reg;
        row_next      = row_reg;
        acc_next      = acc_reg;
        n_next        = n_reg;
        col_next      = col_reg;
        rep_next      = rep_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_offset_next = m_offset_reg;
        m_value_next  = m_value_reg;
        m_span_next   = m_span_reg;
        m_last_next   = m_last_reg;
        pop           = 1'b0;

        case (state_reg)
            B_IDLE: begin
                if (!qstat.empty) begin
                    pop        = 1'b1;
                    state_next = B_FETCH;
                end
            end
            B_FETCH: begin
                cmd_next   = pop_cmd;
                n_next     = '0;
                state_next = (pop_cmd.kind == pcs_pkg::CMD_POST) ? B_TOP : B_CHK;
            end
            B_TOP: begin
                top_byte_next = cmd_reg.aux;
                col_next      = cmd_reg.column;
                rep_next      = cmd_reg.rep;
                state_next    = B_TOT;
            end
            B_TOT: begin
                total_next = inv_rows;
                row_next   = '0;
                acc_next   = '0;
                state_next = B_IDLE;
            end
            B_CHK: begin
                // top row follows the step in force when the pixel arrives
                top_next   = inv_rows;
                state_next = more_rows ? B_MUL : B_IDLE;
            end
            B_MUL: begin
                prod_next = offs_prod[pcs_pkg::OFFS_W-1:0];
                row_next  = row_reg + 1'b1;
                acc_next  = acc_reg + pcs_pkg::ACC_W'(steps.step);
                if (rep_reg != '0) begin
                    n_next = n_reg + 1'b1;
                end
                state_next = B_OUT;
            end
            B_OUT: begin
                if (rep_reg == '0) begin
                    state_next = more_rows ? B_MUL : B_IDLE;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_offset_next = prod_reg + pcs_pkg::OFFS_W'(col_reg);
                    m_value_next  = cmd_reg.data;
                    m_span_next   = rep_reg;
                    m_last_next   = !more_rows;
                    state_next    = more_rows ? B_MUL : B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_valid_reg  <= 1'b0;
            top_byte_reg <= '0;
            top_reg      <= '0;
            total_reg    <= '0;
            row_reg      <= '0;
            acc_reg      <= '0;
            col_reg      <= '0;
            rep_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            top_byte_reg <= top_byte_next;
            top_reg      <= top_next;
            total_reg    <= total_next;
            row_reg      <= row_next;
            acc_reg      <= acc_next;
            col_reg      <= col_next;
            rep_reg      <= rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        n_reg        <= n_next;
        prod_reg     <= prod_next;
        m_offset_reg <= m_offset_next;
        m_value_reg  <= m_value_next;
        m_span_reg   <= m_span_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_offset = m_offset_reg;
    assign m_value  = m_value_reg;
    assign m_span   = m_span_reg;
    assign m_last   = m_last_reg;

endmodule
